FILE: hdl/xkrd_pkg.sv
// Package with item types, result codes and the key table for the keyed record deframer.
package xkrd_pkg;

	localparam int unsigned KEY_LEN = 30;
	localparam int unsigned KEY_POS_W = 5;
	localparam int unsigned HDR_CNT_W = 3;

	// Header byte count at which the record moves into its payload.
	localparam logic [HDR_CNT_W-1:0] HDR_PAYLOAD = 3'd6;
	localparam logic [HDR_CNT_W-1:0] HDR_LEN_HI = 3'd4;
	localparam logic [HDR_CNT_W-1:0] HDR_LEN_LO = 3'd5;
	localparam logic [KEY_POS_W-1:0] KEY_LAST = KEY_POS_W'(KEY_LEN - 1);

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_TRUNC = 2'd2;

	typedef struct packed {
		logic [7:0] file_byte;
		logic end_of_file;
	} in_item_t;

	typedef struct packed {
		logic [31:0] record_timing;
		logic [15:0] record_length;
		logic [7:0] payload_byte;
		logic [1:0] result_kind;
		logic first_of_record;
		logic last_of_record;
		logic file_done;
	} out_item_t;

	function automatic logic [7:0] key_byte(input logic [KEY_POS_W-1:0] pos);
		logic [7:0] k;
		begin
			unique case (pos)
				5'd0: k = 8'hC7;
				5'd1: k = 8'hE0;
				5'd2: k = 8'hEF;
				5'd3: k = 8'hF3;
				5'd4: k = 8'hF1;
				5'd5: k = 8'hF2;
				5'd6: k = 8'hE8;
				5'd7: k = 8'h20;
				5'd8: k = 8'hEA;
				5'd9: k = 8'hE0;
				5'd10: k = 8'hF0;
				5'd11: k = 8'hE0;
				5'd12: k = 8'hEE;
				5'd13: k = 8'hEA;
				5'd14: k = 8'hE5;
				5'd15: k = 8'h20;
				5'd16: k = 8'hED;
				5'd17: k = 8'hE0;
				5'd18: k = 8'h20;
				5'd19: k = 8'hEA;
				5'd20: k = 8'hEE;
				5'd21: k = 8'hEC;
				5'd22: k = 8'hEF;
				5'd23: k = 8'hFC;
				5'd24: k = 8'hFE;
				5'd25: k = 8'hF2;
				5'd26: k = 8'hE5;
				5'd27: k = 8'hF0;
				5'd28: k = 8'hE5;
				5'd29: k = 8'h21;
				default: k = 8'h00;
			endcase
			return k;
		end
	endfunction

endpackage

FILE: hdl/xor_keyed_record_deframer_top.sv
// Top level of the keyed record deframer: input stage, decode and result register.
// Encrypted file bytes enter one per transfer on the byte channel; the last byte of
// a file carries end_of_file. Each byte is XORed with a fixed 30-byte key chosen by
// its position in the file, and the clear stream is parsed as records of a 4-byte
// big-endian timing, a 2-byte big-endian length and that many payload bytes. Every
// payload byte leaves on the rec channel tagged with its record's timing and length;
// a zero-length record gives one empty-record result and a file that ends inside a
// header or payload gives a truncation error. Other header bytes produce no result. The
// block takes one byte per clock cycle with no bubbles while rec_stall does not hold
// back a result: a byte is held in the input register, is decoded by a single stage
// of logic and lands in the result register, which drives rec_valid and holds the
// result until it is transferred out. The only back-pressure comes from the result
// register when rec_stall holds a result.
module xor_keyed_record_deframer_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  xkrd_pkg::in_item_t   byte_item,
	output logic                rec_valid,
	input  logic                rec_stall,
	output xkrd_pkg::out_item_t  rec_item
);
	import xkrd_pkg::*;

	logic valid_s1;
	in_item_t item_s1;
	logic res_valid;
	out_item_t res;
	logic free;
	logic adv;

	// Advance the held byte when it makes no result, or the result register has room.
	assign adv = valid_s1 & (~res_valid | free);

	xkrd_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.adv        (adv),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	// Decrypt, track header and payload, form at most one result per byte.
	xkrd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.item_s1   (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// Hold the result until the downstream transfer completes.
	xkrd_result_reg u_result_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv & res_valid),
		.res       (res),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.rec_item  (rec_item),
		.free      (free)
	);

endmodule

FILE: hdl/xkrd_in_reg.sv
// Input register stage: capture one encrypted byte per transfer.
module xkrd_in_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  xkrd_pkg::in_item_t byte_item,
	input  logic              adv,
	output logic              valid_s1,
	output xkrd_pkg::in_item_t item_s1
);
	import xkrd_pkg::*;

	logic take;

	// Hold the stage while its item cannot move on.
	assign byte_stall = valid_s1 & ~adv;
	assign take = byte_valid & ~byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= byte_item;
		end
	end

endmodule

FILE: hdl/xkrd_decode.sv
// Decrypt and header/payload tracking: state registers and the per-byte result.
module xkrd_decode (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  xkrd_pkg::in_item_t  item_s1,
	output logic               res_valid,
	output xkrd_pkg::out_item_t res
);
	import xkrd_pkg::*;

	logic [KEY_POS_W-1:0] key_pos_q, key_pos_d, kp;
	logic [HDR_CNT_W-1:0] hdr_cnt_q, hdr_cnt_d, hdr_inc;
	logic [31:0] timing_q, timing_d;
	logic [15:0] length_q, length_d;
	logic [15:0] remain_q, remain_d;
	logic [7:0] d;
	logic eof, first, last;

	always_comb begin
		kp = (key_pos_q <= KEY_LAST) ? key_pos_q : '0;
		d = item_s1.file_byte ^ key_byte(kp);
		eof = item_s1.end_of_file;
		key_pos_d = (kp == KEY_LAST) ? '0 : kp + 5'd1;
		hdr_cnt_d = hdr_cnt_q;
		timing_d = timing_q;
		length_d = length_q;
		remain_d = remain_q;
		hdr_inc = hdr_cnt_q + 3'd1;
		first = (remain_q == length_q);
		last = (remain_q <= 16'd1);
		res_valid = 1'b0;
		res = '0;

		if (hdr_cnt_q < HDR_PAYLOAD) begin
			if (hdr_cnt_q == '0) begin
				timing_d = {24'd0, d};
				length_d = '0;
			end else if (hdr_cnt_q < HDR_LEN_HI) begin
				timing_d = {timing_q[23:0], d};
			end else if (hdr_cnt_q == HDR_LEN_HI) begin
				length_d = {8'd0, d};
			end else begin
				length_d = {length_q[7:0], d};
			end
			hdr_cnt_d = hdr_inc;
			res.record_timing = timing_d;
			res.record_length = length_d;
			res.file_done = eof;
			if (hdr_inc == HDR_PAYLOAD) begin
				if (length_d == '0) begin
					res_valid = 1'b1;
					res.result_kind = KIND_EMPTY;
					res.first_of_record = 1'b1;
					res.last_of_record = 1'b1;
					hdr_cnt_d = '0;
				end else begin
					remain_d = length_d;
					res_valid = eof;
					res.result_kind = KIND_TRUNC;
				end
			end else begin
				res_valid = eof;
				res.result_kind = KIND_TRUNC;
			end
		end else begin
			res_valid = 1'b1;
			res.record_timing = timing_q;
			res.record_length = length_q;
			res.file_done = eof;
			if (eof && !last) begin
				res.result_kind = KIND_TRUNC;
			end else begin
				res.result_kind = KIND_PAYLOAD;
				res.payload_byte = d;
				res.first_of_record = first;
				res.last_of_record = last;
			end
			if (last) begin
				remain_d = '0;
				hdr_cnt_d = '0;
			end else begin
				remain_d = remain_q - 16'd1;
			end
		end

		// Restart everything after the final byte of a file.
		if (eof) begin
			key_pos_d = '0;
			hdr_cnt_d = '0;
			timing_d = '0;
			length_d = '0;
			remain_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_pos_q <= '0;
			hdr_cnt_q <= '0;
			timing_q <= '0;
			length_q <= '0;
			remain_q <= '0;
		end else if (step) begin
			key_pos_q <= key_pos_d;
			hdr_cnt_q <= hdr_cnt_d;
			timing_q <= timing_d;
			length_q <= length_d;
			remain_q <= remain_d;
		end
	end

	a_key_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		key_pos_q <= KEY_LAST)
		else $error("key position out of range");

	a_hdr_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_cnt_q <= HDR_PAYLOAD)
		else $error("header count out of range");

	a_eof_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(step && eof) |=> (key_pos_q == '0 && hdr_cnt_q == '0 && remain_q == '0))
		else $error("state not restarted after end of file");

	a_trunc_at_eof: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_valid && res.result_kind == KIND_TRUNC) |-> eof)
		else $error("truncation reported before end of file");

endmodule

FILE: hdl/xkrd_result_reg.sv
// Result register: hold one deframed result until it is transferred.
module xkrd_result_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  xkrd_pkg::out_item_t  res,
	output logic                rec_valid,
	input  logic                rec_stall,
	output xkrd_pkg::out_item_t  rec_item,
	output logic                free
);
	import xkrd_pkg::*;

	// Register can take a new result when empty or being drained this cycle.
	assign free = ~rec_valid | ~rec_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid <= 1'b0;
		end else if (free) begin
			rec_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			rec_item <= res;
		end
	end

endmodule

FILE: sim/xor_keyed_record_deframer_top_tb.sv
// Self-checking testbench for the keyed record deframer: queued byte driver, result monitor.
`timescale 1ns / 1ps

module xor_keyed_record_deframer_top_tb;
	import xkrd_pkg::*;

	// Stop the run here if something hangs.
	localparam int CYCLE_LIMIT = 60000;
	// Cycles to watch for stray results once nothing is expected any more.
	localparam int SETTLE_CYCLES = 12;
	// Rough number of byte transfers to queue in all.
	localparam int TARGET_BYTES = 540;

	// Cipher key, one byte per position in the file modulo 30.
	localparam logic [0:29][7:0] XOR_KEY = {
		8'hC7, 8'hE0, 8'hEF, 8'hF3, 8'hF1, 8'hF2, 8'hE8, 8'h20, 8'hEA, 8'hE0,
		8'hF0, 8'hE0, 8'hEE, 8'hEA, 8'hE5, 8'h20, 8'hED, 8'hE0, 8'h20, 8'hEA,
		8'hEE, 8'hEC, 8'hEF, 8'hFC, 8'hFE, 8'hF2, 8'hE5, 8'hF0, 8'hE5, 8'h21
	};

	typedef logic [7:0] octet_t;

	// One queued byte transfer; hold_for_drain makes the driver wait until every
	// expected result has come back before sending it.
	typedef struct packed {
		logic hold_for_drain;
		in_item_t item;
	} queued_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_stall;
	in_item_t byte_item = '0;
	logic rec_valid;
	logic rec_stall = 1'b0;
	out_item_t rec_item;

	xor_keyed_record_deframer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_item(byte_item),
		.rec_valid(rec_valid),
		.rec_stall(rec_stall),
		.rec_item(rec_item)
	);

	// Stimulus and scoreboard storage.
	queued_byte_t file_stream[$];
	octet_t clear_bytes[$];
	out_item_t expected_recs[$];

	// Deframer state as the testbench sees it.
	logic [KEY_POS_W-1:0] key_pos = '0;
	logic [HDR_CNT_W-1:0] hdr_cnt = '0;
	logic [31:0] timing_acc = '0;
	logic [15:0] length_acc = '0;
	logic [15:0] bytes_left = '0;

	// Bookkeeping.
	int fails = 0;
	int cycle_cnt = 0;
	int queued_bytes = 0;
	int files_queued = 0;
	int sent_cnt = 0;
	int taken_cnt = 0;
	int rec_cnt = 0;
	int payload_cnt = 0;
	int empty_cnt = 0;
	int trunc_cnt = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Work out what one accepted file byte produces and advance the state.
	task automatic deframe_byte(input in_item_t b);
		logic [7:0] clear;
		logic eof;
		logic is_first;
		logic is_last;
		logic produce;
		out_item_t r;
		clear = b.file_byte ^ XOR_KEY[key_pos];
		eof = b.end_of_file;
		key_pos = (key_pos == KEY_LAST) ? '0 : key_pos + 1'b1;
		produce = 1'b0;
		r = '0;
		if (hdr_cnt < HDR_PAYLOAD) begin
			// Shift in the big-endian header: four timing bytes, then two length bytes.
			case (hdr_cnt)
				3'd0: begin
					timing_acc = {24'd0, clear};
					length_acc = '0;
				end
				HDR_LEN_HI: length_acc = {8'd0, clear};
				HDR_LEN_LO: length_acc = {length_acc[7:0], clear};
				default: timing_acc = {timing_acc[23:0], clear};
			endcase
			hdr_cnt = hdr_cnt + 1'b1;
			if (hdr_cnt == HDR_PAYLOAD) begin
				if (length_acc == '0) begin
					// Empty record: one marker result, then straight to the next header.
					produce = 1'b1;
					r.result_kind = KIND_EMPTY;
					r.first_of_record = 1'b1;
					r.last_of_record = 1'b1;
					r.file_done = eof;
					hdr_cnt = '0;
				end else begin
					bytes_left = length_acc;
					if (eof) begin
						produce = 1'b1;
						r.result_kind = KIND_TRUNC;
						r.file_done = 1'b1;
					end
				end
			end else if (eof) begin
				// File ends partway through a header.
				produce = 1'b1;
				r.result_kind = KIND_TRUNC;
				r.file_done = 1'b1;
			end
		end else begin
			is_first = (bytes_left == length_acc);
			is_last = (bytes_left <= 16'd1);
			produce = 1'b1;
			if (eof && !is_last) begin
				// File ends before the payload does: error replaces the byte.
				r.result_kind = KIND_TRUNC;
				r.file_done = 1'b1;
			end else begin
				r.result_kind = KIND_PAYLOAD;
				r.payload_byte = clear;
				r.first_of_record = is_first;
				r.last_of_record = is_last;
				r.file_done = eof;
			end
			if (is_last) begin
				bytes_left = '0;
				hdr_cnt = '0;
			end else begin
				bytes_left = bytes_left - 1'b1;
			end
		end
		if (produce) begin
			r.record_timing = timing_acc;
			r.record_length = length_acc;
			expected_recs.push_back(r);
			case (r.result_kind)
				KIND_PAYLOAD: payload_cnt++;
				KIND_EMPTY: empty_cnt++;
				default: trunc_cnt++;
			endcase
		end
		// End of file returns everything to the reset state.
		if (eof) begin
			key_pos = '0;
			hdr_cnt = '0;
			timing_acc = '0;
			length_acc = '0;
			bytes_left = '0;
		end
	endtask

	task automatic report_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
			fails++;
		end
	endtask

	// Compare one result transfer against the oldest expected record result.
	task automatic check_record(input out_item_t got);
		out_item_t want;
		if (expected_recs.size() == 0) begin
			$display("%0t: unexpected result, expected none, got %p", $time, got);
			fails++;
		end else begin
			want = expected_recs.pop_front();
			report_field("record_timing", want.record_timing, got.record_timing);
			report_field("record_length", 32'(want.record_length),
				32'(got.record_length));
			report_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
			report_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
			report_field("first_of_record", 32'(want.first_of_record),
				32'(got.first_of_record));
			report_field("last_of_record", 32'(want.last_of_record),
				32'(got.last_of_record));
			report_field("file_done", 32'(want.file_done), 32'(got.file_done));
		end
	endtask

	// Append a 6-byte big-endian header to the clear file being built.
	task automatic put_header(input logic [31:0] timing, input logic [15:0] len);
		clear_bytes.push_back(timing[31:24]);
		clear_bytes.push_back(timing[23:16]);
		clear_bytes.push_back(timing[15:8]);
		clear_bytes.push_back(timing[7:0]);
		clear_bytes.push_back(len[15:8]);
		clear_bytes.push_back(len[7:0]);
	endtask

	// Cut the clear file to keep bytes, encrypt it, flag its last byte and queue it.
	task automatic close_file(input logic hold_for_drain, input int keep);
		queued_byte_t q;
		while (clear_bytes.size() > keep)
			void'(clear_bytes.pop_back());
		for (int i = 0; i < clear_bytes.size(); i++) begin
			q.hold_for_drain = (i == 0) ? hold_for_drain : 1'b0;
			q.item.file_byte = clear_bytes[i] ^ XOR_KEY[i % KEY_LEN];
			q.item.end_of_file = (i == clear_bytes.size() - 1);
			file_stream.push_back(q);
		end
		queued_bytes += clear_bytes.size();
		files_queued++;
		clear_bytes.delete();
	endtask

	function automatic logic [31:0] pick_timing();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 19);
		if (r < 3)
			return 0;
		if (r == 3)
			return $urandom_range(30, 70);
		if (r == 4)
			return 1;
		return $urandom_range(1, 12);
	endfunction

	// Driver: new byte at the falling edge, held until the transfer is taken.
	int gap_left = 0;
	logic send_calm;
	always @(negedge clk) begin
		if (arst_n) begin
			// Every fourth stretch of 64 bytes goes with no gaps at all.
			send_calm = ((sent_cnt / 64) % 4) == 3;
			if (byte_valid && sent_cnt != taken_cnt) begin
				// hold: the current byte is still waiting on byte_stall
			end else if (gap_left > 0) begin
				byte_valid <= 1'b0;
				gap_left--;
			end else if (file_stream.size() > 0 &&
					!(file_stream[0].hold_for_drain && expected_recs.size() > 0)) begin
				byte_item <= file_stream[0].item;
				void'(file_stream.pop_front());
				byte_valid <= 1'b1;
				sent_cnt++;
				gap_left = send_calm ? 0 : $urandom_range(0, 3);
			end else begin
				byte_valid <= 1'b0;
			end
		end
	end

	// Receiver: randomly stall each new result, with quiet stretches.
	int stall_left = 0;
	int rec_seen = 0;
	logic stall_armed = 1'b0;
	logic recv_calm;
	always @(negedge clk) begin
		recv_calm = ((rec_cnt / 48) % 4) == 2;
		if (rec_cnt != rec_seen) begin
			rec_seen = rec_cnt;
			stall_armed = 1'b0;
		end
		if (rec_valid && !stall_armed) begin
			stall_armed = 1'b1;
			stall_left = recv_calm ? 0 : $urandom_range(0, 3);
		end
		if (stall_left > 0) begin
			rec_stall <= 1'b1;
			stall_left--;
		end else begin
			rec_stall <= 1'b0;
		end
	end

	// Monitor: sample both channels at the rising edge; predict before checking.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, expected_recs.size());
			$display("** xor_keyed_record_deframer_top: FAILED **");
			$finish;
		end else if (arst_n) begin
			if (byte_valid && !byte_stall) begin
				deframe_byte(byte_item);
				taken_cnt++;
			end
			if (rec_valid && !rec_stall) begin
				check_record(rec_item);
				rec_cnt++;
			end
		end
	end

	initial begin
		int style;
		int nrec;
		int len;
		// Directed files first.
		// Record that ends exactly on the last byte, extreme timing and payload values.
		put_header(32'hFFFF_FFFF, 16'd2);
		clear_bytes.push_back(8'h00);
		clear_bytes.push_back(8'hFF);
		close_file(1'b0, clear_bytes.size());
		// Empty record closing the file.
		put_header(32'h0000_0000, 16'd0);
		close_file(1'b0, 6);
		// File ends inside the timing field; pause for results before it.
		put_header(32'h1234_5678, 16'd9);
		close_file(1'b1, 3);
		// One-byte file.
		put_header(32'hA5A5_A5A5, 16'd3);
		close_file(1'b0, 1);
		// Header complete on the last byte with a nonzero length.
		put_header(32'h8000_0001, 16'd2);
		close_file(1'b0, 6);
		// Largest length, file ends after one payload byte.
		put_header(32'h0000_0000, 16'hFFFF);
		clear_bytes.push_back(8'h5A);
		close_file(1'b0, 7);

		// Random files: mostly well-formed records, some cut short, some noise.
		while (queued_bytes < TARGET_BYTES) begin
			style = $urandom_range(0, 15);
			if (style == 0) begin
				len = $urandom_range(1, 12);
				repeat (len) clear_bytes.push_back(octet_t'($urandom_range(0, 255)));
				close_file(1'b0, len);
			end else if (style == 1) begin
				// Random length, mostly big, with a payload that is usually cut off partway.
				put_header(pick_timing(), 16'($urandom_range(2, 65535)));
				repeat ($urandom_range(0, 4))
					clear_bytes.push_back(octet_t'($urandom_range(0, 255)));
				close_file(1'b0, clear_bytes.size());
			end else begin
				nrec = $urandom_range(1, 4);
				repeat (nrec) begin
					len = pick_length();
					put_header(pick_timing(), 16'(len));
					repeat (len) clear_bytes.push_back(octet_t'($urandom_range(0, 255)));
				end
				if (style <= 4)
					close_file(1'b0, $urandom_range(1, clear_bytes.size()));
				else
					close_file(style == 5, clear_bytes.size());
			end
		end

		// Hold reset, then release it at a falling edge.
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for the last byte to go out, then for every result to come back.
		while (file_stream.size() != 0 || sent_cnt != taken_cnt)
			@(posedge clk);
		while (expected_recs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (expected_recs.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_recs.size());
			fails++;
		end
		$display("Sent %0d files in %0d bytes; checked %0d results:", files_queued, taken_cnt,
			rec_cnt);
		$display("  %0d payload bytes, %0d empty records, %0d truncations, %0d mismatches",
			payload_cnt, empty_cnt, trunc_cnt, fails);
		if (fails == 0) begin
			$display("** xor_keyed_record_deframer_top: PASSED **");
		end else begin
			$display("** xor_keyed_record_deframer_top: FAILED **");
		end
		$finish;
	end

endmodule
